FILE: design/tcpots_pkg.sv
// ----------------------------------------------------------------------------
// tcpots_pkg
// shared constants and types for the tcp option timestamp / window scale scanner
// ----------------------------------------------------------------------------
package tcpots_pkg;

    localparam logic [7:0] C_KIND_EOL    = 8'd0;
    localparam logic [7:0] C_KIND_NOP    = 8'd1;
    localparam logic [7:0] C_KIND_WSCALE = 8'd3;
    localparam logic [7:0] C_KIND_TS     = 8'd8;
    localparam logic [7:0] C_MIN_OPT_LEN = 8'd2;
    localparam logic [7:0] C_MAX_SHIFT   = 8'd14;
    localparam logic [5:0] C_POS_MAX     = 6'd63;
    // fixed 20 byte header plus walk / timestamp margins
    localparam logic [6:0] C_WALK_BIAS   = 7'd23;
    localparam logic [6:0] C_TS_BIAS     = 7'd30;
    localparam logic [2:0] C_TS_BYTES    = 3'd4;

    typedef struct packed {
        logic       ts_accept;
        logic       ws_accept;
        logic [5:0] pos;
    } t_walk_evt;

endpackage

FILE: design/tcpots_walk.sv
// ----------------------------------------------------------------------------
// tcpots_walk
// option list walker: tracks byte position, next option start and stop state
// ----------------------------------------------------------------------------
module tcpots_walk
    import tcpots_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic            i_clear,
    input  logic [7:0]      i_byte,
    input  logic [3:0]      i_header_words,
    output t_walk_evt       o_evt
);

    logic [5:0] r_pos;
    logic [5:0] n_pos;
    logic [8:0] r_next_start;
    logic [8:0] n_next_start;
    logic       r_expect;
    logic       n_expect;
    logic       r_stopped;
    logic       n_stopped;
    logic [6:0] hdr_bytes;
    logic [6:0] walk_pos;
    logic [6:0] ts_pos;

    assign hdr_bytes = {1'b0, i_header_words, 2'b00};
    assign walk_pos  = {1'b0, r_pos} + C_WALK_BIAS;
    assign ts_pos    = {1'b0, r_pos} + C_TS_BIAS;

    always_comb begin
        n_pos           = r_pos;
        n_next_start    = r_next_start;
        n_expect        = r_expect;
        n_stopped       = r_stopped;
        o_evt.pos       = r_pos;
        o_evt.ts_accept = 1'b0;
        o_evt.ws_accept = 1'b0;
        if (i_take) begin
            if (!r_stopped) begin
                if (r_expect) begin
                    n_expect = 1'b0;
                    if (i_byte < C_MIN_OPT_LEN) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_next_start = {3'b000, r_pos} + {1'b0, i_byte} - 9'd1;
                    end
                end else if ({3'b000, r_pos} == r_next_start) begin
                    if (walk_pos > hdr_bytes) begin
                        n_stopped = 1'b1;
                    end else if (i_byte == C_KIND_EOL) begin
                        n_stopped = 1'b1;
                    end else if (i_byte == C_KIND_NOP) begin
                        n_next_start = {3'b000, r_pos} + 9'd1;
                    end else begin
                        o_evt.ts_accept = (i_byte == C_KIND_TS) && (ts_pos <= hdr_bytes);
                        o_evt.ws_accept = (i_byte == C_KIND_WSCALE);
                        n_expect        = 1'b1;
                    end
                end
            end
            if (r_pos != C_POS_MAX) begin
                n_pos = r_pos + 6'd1;
            end
        end
        if (i_clear) begin
            n_pos        = '0;
            n_next_start = '0;
            n_expect     = 1'b0;
            n_stopped    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_next_start <= '0;
            r_expect     <= 1'b0;
            r_stopped    <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_next_start <= n_next_start;
            r_expect     <= n_expect;
            r_stopped    <= n_stopped;
        end
    end

endmodule

FILE: design/tcpots_capture.sv
// ----------------------------------------------------------------------------
// tcpots_capture
// captures timestamp and window scale bytes and forms the segment result
// ----------------------------------------------------------------------------
module tcpots_capture
    import tcpots_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic            i_clear,
    input  logic [7:0]      i_byte,
    input  t_walk_evt       i_evt,
    output logic            o_ts_found,
    output logic [31:0]     o_ts_value,
    output logic            o_wscale_found,
    output logic [14:0]     o_window_factor
);

    logic [2:0]  r_ts_left;
    logic [2:0]  n_ts_left;
    logic [5:0]  r_ts_start;
    logic [5:0]  n_ts_start;
    logic [31:0] r_ts_shift;
    logic [31:0] n_ts_shift;
    logic        r_ts_seen;
    logic        n_ts_seen;
    logic [5:0]  r_ws_at;
    logic [5:0]  n_ws_at;
    logic        r_ws_pending;
    logic        n_ws_pending;
    logic        r_ws_seen;
    logic        n_ws_seen;
    logic [14:0] r_ws_factor;
    logic [14:0] n_ws_factor;
    logic [3:0]  shift_amt;
    logic [31:0] ts_aligned;

    assign shift_amt = (i_byte > C_MAX_SHIFT) ? C_MAX_SHIFT[3:0] : i_byte[3:0];

    always_comb begin
        n_ts_left    = r_ts_left;
        n_ts_start   = r_ts_start;
        n_ts_shift   = r_ts_shift;
        n_ts_seen    = r_ts_seen;
        n_ws_at      = r_ws_at;
        n_ws_pending = r_ws_pending;
        n_ws_seen    = r_ws_seen;
        n_ws_factor  = r_ws_factor;
        if (i_take) begin
            if ((r_ts_left != 3'd0) && (i_evt.pos == r_ts_start)) begin
                n_ts_shift = {r_ts_shift[23:0], i_byte};
                n_ts_start = r_ts_start + 6'd1;
                n_ts_left  = r_ts_left - 3'd1;
            end
            if (r_ws_pending && (i_evt.pos == r_ws_at)) begin
                n_ws_factor  = 15'd1 << shift_amt;
                n_ws_pending = 1'b0;
            end
            // a newer option restarts any capture of the same kind
            if (i_evt.ts_accept) begin
                n_ts_seen  = 1'b1;
                n_ts_shift = '0;
                n_ts_left  = C_TS_BYTES;
                n_ts_start = i_evt.pos + 6'd2;
            end
            if (i_evt.ws_accept) begin
                n_ws_seen    = 1'b1;
                n_ws_pending = 1'b1;
                n_ws_factor  = 15'd1;
                n_ws_at      = i_evt.pos + 6'd2;
            end
        end
    end

    // missing timestamp bytes count as zero
    always_comb begin
        case (n_ts_left)
            3'd0:    ts_aligned = n_ts_shift;
            3'd1:    ts_aligned = {n_ts_shift[23:0], 8'h00};
            3'd2:    ts_aligned = {n_ts_shift[15:0], 16'h0000};
            3'd3:    ts_aligned = {n_ts_shift[7:0], 24'h000000};
            default: ts_aligned = '0;
        endcase
    end

    assign o_ts_found      = n_ts_seen;
    assign o_ts_value      = n_ts_seen ? ts_aligned : 32'd0;
    assign o_wscale_found  = n_ws_seen;
    assign o_window_factor = n_ws_factor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_ts_left    <= '0;
            r_ts_start   <= '0;
            r_ts_shift   <= '0;
            r_ts_seen    <= 1'b0;
            r_ws_at      <= '0;
            r_ws_pending <= 1'b0;
            r_ws_seen    <= 1'b0;
            r_ws_factor  <= 15'd1;
        end else begin
            r_ts_left    <= n_ts_left;
            r_ts_start   <= n_ts_start;
            r_ts_shift   <= n_ts_shift;
            r_ts_seen    <= n_ts_seen;
            r_ws_at      <= n_ws_at;
            r_ws_pending <= n_ws_pending;
            r_ws_seen    <= n_ws_seen;
            r_ws_factor  <= n_ws_factor;
        end
    end

endmodule

FILE: design/tcp_option_ts_wscale_scanner_unit.sv
// ----------------------------------------------------------------------------
// tcp_option_ts_wscale_scanner_unit
// scans a tcp options area one byte per transfer and reports timestamp and
// window scale factor on the last byte of each segment
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_stall   option_byte, byte_valid, header_words, last
// out       output     o_out_valid / i_out_stall ts_found, ts_value, wscale_found,
//                                                window_factor
//
// one input transfer per cycle while o_in_stall is low
// a result is valid in the cycle after the last byte leaves the input register
// synchronous active-low reset clears walk and capture state
// a held result stalls the input only when a last byte waits behind it
// ----------------------------------------------------------------------------
module tcp_option_ts_wscale_scanner_unit
    import tcpots_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_option_byte,
    input  logic        i_byte_valid,
    input  logic [3:0]  i_header_words,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_ts_found,
    output logic [31:0] o_ts_value,
    output logic        o_wscale_found,
    output logic [14:0] o_window_factor
);

    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_bvalid;
    logic [3:0]  r_in_hw;
    logic        r_in_last;
    logic        r_out_vld;
    logic        r_ts_found;
    logic [31:0] r_ts_value;
    logic        r_ws_found;
    logic [14:0] r_win_factor;
    logic        out_free;
    logic        proc_go;
    logic        take;
    logic        seg_end;
    logic        in_xfer;
    t_walk_evt   walk_evt;
    logic        cap_ts_found;
    logic [31:0] cap_ts_value;
    logic        cap_ws_found;
    logic [14:0] cap_win_factor;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign proc_go    = r_in_vld && (!r_in_last || out_free);
    assign take       = proc_go && r_in_bvalid;
    assign seg_end    = proc_go && r_in_last;
    assign o_in_stall = r_in_vld && !proc_go;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (proc_go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte   <= i_option_byte;
            r_in_bvalid <= i_byte_valid;
            r_in_hw     <= i_header_words;
            r_in_last   <= i_last;
        end
    end

    tcpots_walk u_walk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_clear        (seg_end),
        .i_byte         (r_in_byte),
        .i_header_words (r_in_hw),
        .o_evt          (walk_evt)
    );

    tcpots_capture u_capture (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_clear         (seg_end),
        .i_byte          (r_in_byte),
        .i_evt           (walk_evt),
        .o_ts_found      (cap_ts_found),
        .o_ts_value      (cap_ts_value),
        .o_wscale_found  (cap_ws_found),
        .o_window_factor (cap_win_factor)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (seg_end) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seg_end) begin
            r_ts_found   <= cap_ts_found;
            r_ts_value   <= cap_ts_value;
            r_ws_found   <= cap_ws_found;
            r_win_factor <= cap_win_factor;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_ts_found      = r_ts_found;
    assign o_ts_value      = r_ts_value;
    assign o_wscale_found  = r_ws_found;
    assign o_window_factor = r_win_factor;

`ifndef SYNTHESIS
    a_factor_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot(o_window_factor))
        else $error("window factor not a power of two");

    a_ts_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ts_found) |-> (o_ts_value == 32'd0))
        else $error("timestamp value without timestamp option");

    a_ws_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_wscale_found) |-> (o_window_factor == 15'd1))
        else $error("window factor not default without scale option");

    a_seg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seg_end |=> (walk_evt.pos == 6'd0))
        else $error("byte position not cleared after segment end");
`endif

endmodule
